// ===== design/id_map_with_free_pool_top_defines.svh =====
// Assertion macros used by the id map top design file.
`ifndef ID_MAP_WITH_FREE_POOL_TOP_DEFINES_SVH
`define ID_MAP_WITH_FREE_POOL_TOP_DEFINES_SVH

// Property on clk, disabled during reset.
`define IDM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property on clk, checked during reset as well.
`define IDM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/idm_pkg.sv =====
// ----------------------------------------------------------------------------
// idm_pkg
// Command and status codes, field widths and cell control types.
// ----------------------------------------------------------------------------
package idm_pkg;

  localparam int CMD_W    = 2;
  localparam int IN_ID_W  = 32;
  localparam int SLOT_W   = 6;
  localparam int STATUS_W = 3;

  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CREATE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EXISTS    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

  // Broadcast phase-two control to every cell.
  typedef struct packed {
    logic clear;
    logic map_wr;    // create: write chosen entry
    logic map_free;  // delete: free chosen entry
    logic pool_take; // create: empty chosen pool position
    logic pool_put;  // delete: fill chosen pool position
  } cell_ctrl_t;

endpackage

// ===== design/idm_if.sv =====
// ----------------------------------------------------------------------------
// idm_req_if / idm_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface idm_req_if;
  logic                         valid;
  logic                         ready;
  logic [idm_pkg::CMD_W-1:0]    command;
  logic [idm_pkg::IN_ID_W-1:0]  entity_id;
  modport source (output valid, command, entity_id, input ready);
  modport sink   (input valid, command, entity_id, output ready);
endinterface

interface idm_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [idm_pkg::SLOT_W-1:0]    slot_number;
  logic [idm_pkg::STATUS_W-1:0]  status;
  modport source (output valid, slot_number, status, input ready);
  modport sink   (input valid, slot_number, status, output ready);
endinterface

// ===== design/idm_cell.sv =====
// ----------------------------------------------------------------------------
// idm_cell
// One map entry and one pool position with match flags and a priority chain.
// ----------------------------------------------------------------------------
module idm_cell #(
  parameter int ID_BITS = 32,
  parameter int INDEX   = 0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [ID_BITS-1:0]     req_id,
  input  logic                   snapshot,
  input  idm_pkg::cell_ctrl_t    ctrl,
  input  logic [idm_pkg::SLOT_W-1:0] put_slot,
  input  logic [idm_pkg::SLOT_W-1:0] take_slot,
  input  logic                   hit_in,
  input  logic                   free_in,
  input  logic                   occ_in,
  input  logic                   emp_in,
  output logic                   hit_out,
  output logic                   free_out,
  output logic                   occ_out,
  output logic                   emp_out,
  output logic                   hit_first,
  output logic                   free_first,
  output logic                   occ_first,
  output logic                   emp_first,
  output logic [idm_pkg::SLOT_W-1:0] entry_slot,
  output logic [idm_pkg::SLOT_W-1:0] pool_slot
);
  import idm_pkg::*;

  localparam logic [SLOT_W-1:0] OWN = SLOT_W'(INDEX);

  logic                valid_r;
  logic [ID_BITS-1:0]  ent_r;
  logic [SLOT_W-1:0]   eslot_r;
  logic [SLOT_W-1:0]   pval_r;
  logic                pocc_r;
  logic                hit_r, free_r;

  // Match flags registered at snapshot; chain decides lowest in phase two.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pocc_r  <= 1'b1;
      pval_r  <= OWN;
      eslot_r <= '0;
      hit_r   <= 1'b0;
      free_r  <= 1'b0;
    end else begin
      if (snapshot) begin
        hit_r  <= valid_r && (ent_r == req_id);
        free_r <= !valid_r;
      end
      if (ctrl.clear) begin
        valid_r <= 1'b0;
        pocc_r  <= 1'b1;
        pval_r  <= OWN;
        eslot_r <= '0;
      end else begin
        if (ctrl.map_wr && free_first) begin
          valid_r <= 1'b1;
          ent_r   <= req_id;
          eslot_r <= take_slot;
        end
        if (ctrl.map_free && hit_first) begin
          valid_r <= 1'b0;
          eslot_r <= '0;
        end
        if (ctrl.pool_take && occ_first) pocc_r <= 1'b0;
        if (ctrl.pool_put && emp_first) begin
          pocc_r <= 1'b1;
          pval_r <= put_slot;
        end
      end
    end
  end

  assign hit_first  = hit_r && !hit_in;
  assign free_first = free_r && !free_in;
  assign occ_first  = pocc_r && !occ_in;
  assign emp_first  = !pocc_r && !emp_in;
  assign hit_out    = hit_in || hit_r;
  assign free_out   = free_in || free_r;
  assign occ_out    = occ_in || pocc_r;
  assign emp_out    = emp_in || !pocc_r;
  assign entry_slot = eslot_r;
  assign pool_slot  = pval_r;

endmodule

// ===== design/id_map_with_free_pool_top.sv =====
// ----------------------------------------------------------------------------
// id_map_with_free_pool_top
// Entity id to slot map with a free pool, built as a row of cells.
// ----------------------------------------------------------------------------
// Usage: requests (command, entity_id) enter on in_req; one result
// (slot_number, status) per request leaves on out_rsp. Both are valid/ready.
// A request passes through the latch, compare and execute phases of the
// controller: the cycle it is accepted the id is latched, the next cycle
// every cell compares it and registers its match flags, and in the execute
// phase, once the output register can take the result, the priority chain
// through the row picks the lowest matching entry and pool position, the
// cells update and the result is registered. Requests are taken only in idle.
// A result waiting on a stalled receiver sits in the output register;
// the next request is accepted meanwhile and is held in its final phase
// until that register drains.
// Reset (synchronous, active low) empties the map and fills the pool with
// slots 0..TABLE_SIZE-1; the clear command does the same.
// ----------------------------------------------------------------------------
`include "id_map_with_free_pool_top_defines.svh"

module id_map_with_free_pool_top #(
  parameter int TABLE_SIZE = 64,
  parameter int ID_BITS    = 32
) (
  input logic clk,
  input logic rst_n,
  idm_req_if.sink   in_req,
  idm_rsp_if.source out_rsp
);
  import idm_pkg::*;

  localparam logic [ID_BITS-1:0] INVALID = '1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_EXE  = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [CMD_W-1:0]    cmd_r;
  logic [ID_BITS-1:0]  id_r;
  logic                ovalid_r;
  logic [SLOT_W-1:0]   oslot_r, oslot_nxt;
  logic [STATUS_W-1:0] ost_r, ost_nxt;

  logic [TABLE_SIZE:0] hit_c, free_c, occ_c, emp_c;
  logic [TABLE_SIZE-1:0] hit_f, free_f, occ_f, emp_f;
  logic [SLOT_W-1:0] eslot [TABLE_SIZE];
  logic [SLOT_W-1:0] pslot [TABLE_SIZE];
  logic [SLOT_W-1:0] hit_slot, take_slot;
  cell_ctrl_t ctrl;
  logic exe_go, id_bad;

  assign hit_c[0] = 1'b0;
  assign free_c[0] = 1'b0;
  assign occ_c[0] = 1'b0;
  assign emp_c[0] = 1'b0;

  assign exe_go = (state_r == S_EXE) && (!ovalid_r || out_rsp.ready);
  assign id_bad = (id_r == INVALID);

  for (genvar i = 0; i < TABLE_SIZE; i++) begin : g_cell
    idm_cell #(.ID_BITS(ID_BITS), .INDEX(i)) u_cell (
      .clk, .rst_n,
      .req_id(id_r), .snapshot(state_r == S_CMP), .ctrl,
      .put_slot(hit_slot), .take_slot,
      .hit_in(hit_c[i]), .free_in(free_c[i]), .occ_in(occ_c[i]), .emp_in(emp_c[i]),
      .hit_out(hit_c[i+1]), .free_out(free_c[i+1]),
      .occ_out(occ_c[i+1]), .emp_out(emp_c[i+1]),
      .hit_first(hit_f[i]), .free_first(free_f[i]),
      .occ_first(occ_f[i]), .emp_first(emp_f[i]),
      .entry_slot(eslot[i]), .pool_slot(pslot[i])
    );
  end

  // One-hot selects, so an OR gathers the chosen slot.
  always_comb begin
    hit_slot  = '0;
    take_slot = '0;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      hit_slot  = hit_slot | (hit_f[i] ? eslot[i] : '0);
      take_slot = take_slot | (occ_f[i] ? pslot[i] : '0);
    end
  end

  always_comb begin
    ctrl      = '0;
    oslot_nxt = '0;
    ost_nxt   = ST_OK;
    unique case (cmd_r)
      CMD_CLEAR: ctrl.clear = exe_go;
      CMD_LOOKUP: begin
        if (id_bad) ost_nxt = ST_INVALID;
        else if (!hit_c[TABLE_SIZE]) ost_nxt = ST_NOT_FOUND;
        else oslot_nxt = hit_slot;
      end
      CMD_CREATE: begin
        if (id_bad) ost_nxt = ST_INVALID;
        else if (hit_c[TABLE_SIZE]) ost_nxt = ST_EXISTS;
        else if (!free_c[TABLE_SIZE] || !occ_c[TABLE_SIZE]) ost_nxt = ST_FULL;
        else begin
          oslot_nxt      = take_slot;
          ctrl.map_wr    = exe_go;
          ctrl.pool_take = exe_go;
        end
      end
      default: begin
        if (id_bad) ost_nxt = ST_INVALID;
        else if (!hit_c[TABLE_SIZE]) ost_nxt = ST_NOT_FOUND;
        else begin
          oslot_nxt     = hit_slot;
          ctrl.map_free = exe_go;
          ctrl.pool_put = exe_go;
        end
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_req.valid) state_nxt = S_CMP;
      S_CMP:   state_nxt = S_EXE;
      S_EXE:   if (exe_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (exe_go) ovalid_r <= 1'b1;
      else if (out_rsp.ready) ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      cmd_r <= in_req.command;
      id_r  <= ID_BITS'(in_req.entity_id);
    end
    if (exe_go) begin
      oslot_r <= oslot_nxt;
      ost_r   <= ost_nxt;
    end
  end

  assign in_req.ready        = (state_r == S_IDLE);
  assign out_rsp.valid       = ovalid_r;
  assign out_rsp.slot_number = oslot_r;
  assign out_rsp.status      = ost_r;

  `IDM_ASSERT(a_exe_from_cmp, clk, rst_n, (state_r == S_EXE) |-> ($past(state_r) == S_CMP || $past(state_r) == S_EXE), "execute not after compare")
  `IDM_ASSERT(a_one_hit, clk, rst_n, $countones(hit_f) <= 1, "several entries chosen")
  `IDM_ASSERT(a_one_pick, clk, rst_n, ($countones(free_f) <= 1) && ($countones(emp_f) <= 1), "several free positions chosen")
  `IDM_ASSERT(a_result_after_exe, clk, rst_n, $rose(out_rsp.valid) |-> $past(exe_go), "result without execution")
  `IDM_ASSERT_ALWAYS(a_reset_idle, clk, ($past(rst_n) === 1'b0) |-> (state_r == S_IDLE), "not idle after reset")

endmodule

// ===== tb/tb_id_map_with_free_pool_top.sv =====
// ----------------------------------------------------------------------------
// tb_id_map_with_free_pool_top
// Self-checking bench for the entity id to slot map with free pool.
// A short table of directed requests covers each command, the reserved id,
// duplicates, misses and clear. A random run follows, mostly creates, deletes
// and lookups over a small id set so the table fills and drains. Every result
// is checked against a behavioural model of the map and pool, or for a typed
// directed row against its hand-written answer. The sender idles in bursts,
// the receiver stalls on its own pattern and once holds off to back it up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_id_map_with_free_pool_top;
  import idm_pkg::*;

  localparam int ENTRIES   = 64;
  localparam int N_RANDOM  = 900;
  localparam int IDLE_MAX  = 5000;
  localparam logic [IN_ID_W-1:0] BAD_ID = '1;

  typedef struct {
    logic [CMD_W-1:0]    cmd;
    logic [IN_ID_W-1:0]  id;
    bit                  typed;
    logic [SLOT_W-1:0]   slot;
    logic [STATUS_W-1:0] st;
  } row_t;

  typedef struct {
    logic [SLOT_W-1:0]   slot;
    logic [STATUS_W-1:0] st;
  } rsp_t;

  logic clk;
  logic rst_n;
  idm_req_if in_req ();
  idm_rsp_if out_rsp ();

  id_map_with_free_pool_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req.sink),
    .out_rsp (out_rsp.source)
  );

  logic [IN_ID_W-1:0] map_id [ENTRIES];
  logic [SLOT_W-1:0]  map_slot [ENTRIES];
  logic [SLOT_W-1:0]  pool_slot [ENTRIES];
  bit                 pool_full [ENTRIES];

  rsp_t pending_rsp[$];
  rsp_t typed_rsp[$];
  bit   typed_flag[$];
  int   errors = 0;
  int   accepted_reqs = 0;
  int   idle_cycles = 0;
  bit   stim_done = 0;

  function automatic void empty_map();
    for (int i = 0; i < ENTRIES; i++) begin
      map_id[i] = BAD_ID;
      map_slot[i] = '0;
      pool_slot[i] = SLOT_W'(i);
      pool_full[i] = 1'b1;
    end
  endfunction

  function automatic int find_id(logic [IN_ID_W-1:0] id);
    for (int i = 0; i < ENTRIES; i++)
      if (map_id[i] == id) return i;
    return -1;
  endfunction

  function automatic int find_pool(bit full);
    for (int i = 0; i < ENTRIES; i++)
      if (pool_full[i] == full) return i;
    return -1;
  endfunction

  function automatic rsp_t map_request(logic [CMD_W-1:0] cmd, logic [IN_ID_W-1:0] id);
    rsp_t r;
    int e;
    int p;
    r.slot = '0;
    r.st = ST_OK;
    if (cmd == CMD_CLEAR) begin
      empty_map();
    end else if (id == BAD_ID) begin
      r.st = ST_INVALID;
    end else if (cmd == CMD_LOOKUP) begin
      e = find_id(id);
      if (e < 0) r.st = ST_NOT_FOUND;
      else r.slot = map_slot[e];
    end else if (cmd == CMD_CREATE) begin
      if (find_id(id) >= 0) begin
        r.st = ST_EXISTS;
      end else begin
        e = find_id(BAD_ID);
        p = find_pool(1'b1);
        if (e < 0 || p < 0) begin
          r.st = ST_FULL;
        end else begin
          map_id[e] = id;
          map_slot[e] = pool_slot[p];
          pool_full[p] = 1'b0;
          r.slot = pool_slot[p];
        end
      end
    end else begin
      e = find_id(id);
      if (e < 0) begin
        r.st = ST_NOT_FOUND;
      end else begin
        r.slot = map_slot[e];
        map_id[e] = BAD_ID;
        map_slot[e] = '0;
        p = find_pool(1'b0);
        if (p >= 0) begin
          pool_slot[p] = r.slot;
          pool_full[p] = 1'b1;
        end
      end
    end
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // accepted requests feed the model; accepted results are checked
  always @(posedge clk) begin
    rsp_t want;
    if (in_req.valid && in_req.ready) begin
      pending_rsp.push_back(map_request(in_req.command, in_req.entity_id));
      accepted_reqs++;
    end
    if (out_rsp.valid && out_rsp.ready) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected result slot %0d status %0d", $time,
                 out_rsp.slot_number, out_rsp.status);
        errors++;
      end else begin
        want = pending_rsp.pop_front();
        if (typed_flag.size() != 0 && typed_flag.pop_front()) begin
          // typed directed rows carry a hand-written answer that replaces the model's
          want = typed_rsp.pop_front();
        end
        if (out_rsp.slot_number !== want.slot)begin
          $display("%0t: slot expected %0d actual %0d", $time, want.slot,
                   out_rsp.slot_number);
          errors++;
        end
        if (out_rsp.status !== want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st,
                   out_rsp.status);
          errors++;
        end
      end
    end
    if ((in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_MAX) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: random stalls, quiet stretches and one long hold-off
  initial begin
    bit held;
    held = 1'b0;
    out_rsp.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (!held && accepted_reqs > 300) begin
        held = 1'b1;
        out_rsp.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            out_rsp.ready <= 1'b1;
            repeat ($urandom_range(10, 60)) @(posedge clk);
          end
          1: begin
            out_rsp.ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
          end
          default: begin
            out_rsp.ready <= 1'($urandom_range(0, 1));
            @(posedge clk);
          end
        endcase
      end
    end
  end

  task automatic send(logic [CMD_W-1:0] cmd, logic [IN_ID_W-1:0] id);
    in_req.valid <= 1'b1;
    in_req.command <= cmd;
    in_req.entity_id <= id;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
  endtask

  task automatic pause_sender();
    in_req.valid <= 1'b0;
    repeat ($urandom_range(1, 12)) @(posedge clk);
  endtask

  function automatic logic [IN_ID_W-1:0] pick_id();
    case ($urandom_range(0, 19))
      0: return BAD_ID;
      1: return $urandom();
      2: return BAD_ID - IN_ID_W'($urandom_range(1, 4));
      default: return IN_ID_W'($urandom_range(0, 79)) | (IN_ID_W'($urandom_range(0, 3)) << 30);
    endcase
  endfunction

  row_t script[] = '{
    '{CMD_LOOKUP, 32'd0,        1'b1, 6'd0, ST_NOT_FOUND},
    '{CMD_CREATE, BAD_ID,       1'b1, 6'd0, ST_INVALID},
    '{CMD_LOOKUP, BAD_ID,       1'b1, 6'd0, ST_INVALID},
    '{CMD_DELETE, BAD_ID,       1'b1, 6'd0, ST_INVALID},
    '{CMD_DELETE, 32'd7,        1'b1, 6'd0, ST_NOT_FOUND},
    '{CMD_CREATE, 32'd0,        1'b1, 6'd0, ST_OK},
    '{CMD_CREATE, 32'd0,        1'b1, 6'd0, ST_EXISTS},
    '{CMD_CREATE, 32'hFFFFFFFE, 1'b1, 6'd1, ST_OK},
    '{CMD_LOOKUP, 32'hFFFFFFFE, 1'b1, 6'd1, ST_OK},
    '{CMD_CREATE, 32'h80000000, 1'b1, 6'd2, ST_OK},
    '{CMD_DELETE, 32'd0,        1'b1, 6'd0, ST_OK},
    '{CMD_DELETE, 32'd0,        1'b1, 6'd0, ST_NOT_FOUND},
    '{CMD_CREATE, 32'h55555555, 1'b0, 6'd0, ST_OK},
    '{CMD_CREATE, 32'hAAAAAAAA, 1'b0, 6'd0, ST_OK},
    '{CMD_DELETE, 32'h80000000, 1'b0, 6'd0, ST_OK},
    '{CMD_LOOKUP, 32'h55555555, 1'b0, 6'd0, ST_OK},
    '{CMD_CLEAR,  32'h12345678, 1'b1, 6'd0, ST_OK},
    '{CMD_LOOKUP, 32'h55555555, 1'b1, 6'd0, ST_NOT_FOUND},
    '{CMD_CREATE, 32'h0000FFFF, 1'b1, 6'd0, ST_OK},
    '{CMD_CLEAR,  BAD_ID,       1'b1, 6'd0, ST_OK}
  };

  initial begin
    rsp_t r;
    int burst;
    int op;
    empty_map();
    rst_n <= 1'b0;
    in_req.valid <= 1'b0;
    in_req.command <= CMD_LOOKUP;
    in_req.entity_id <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      r.slot = script[i].slot;
      r.st = script[i].st;
      typed_flag.push_back(script[i].typed);
      if (script[i].typed) typed_rsp.push_back(r);
      send(script[i].cmd, script[i].id);
      if ($urandom_range(0, 2) == 0) pause_sender();
    end

    burst = 0;
    for (int n = 0; n < N_RANDOM; n++) begin
      // long create-heavy and delete-heavy phases let the table fill and drain
      op = $urandom_range(0, 99);
      if (op < 2) send(CMD_CLEAR, $urandom());
      else if (op < 30) send(CMD_LOOKUP, pick_id());
      else if ((n / 150) % 2 == 0) send(op < 80 ? CMD_CREATE : CMD_DELETE, pick_id());
      else send(op < 80 ? CMD_DELETE : CMD_CREATE, pick_id());
      if (burst == 0) begin
        if ($urandom_range(0, 1)) pause_sender();
        burst = $urandom_range(0, 30);
      end else begin
        burst--;
      end
    end
    in_req.valid <= 1'b0;
    @(posedge clk);

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
